// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros, included by http_request_head_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/hrhc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrhc_pkg
// Types shared by the request-head checker: item structs and error codes.
// ----------------------------------------------------------------------------
package hrhc_pkg;

  // Error codes reported in the verdict
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_REQ_LINE  = 3'd1,
    ERR_FOLDED    = 3'd2,
    ERR_NO_COLON  = 3'd3,
    ERR_BAD_LEN   = 3'd4,
    ERR_CONFLICT  = 3'd5,
    ERR_CHUNKED   = 3'd6,
    ERR_TOO_LARGE = 3'd7
  } err_code_t;

  // One input item: a head byte and its end flag
  typedef struct packed {
    logic [7:0] head_byte;
    logic       last;
  } in_item_t;

  // One result item: the verdict for a whole head
  typedef struct packed {
    logic        accepted;
    logic [2:0]  error_code;
    logic [63:0] body_length;
  } out_item_t;

  // Head summary from the parser, before the size limit is applied
  typedef struct packed {
    err_code_t   err;
    logic [63:0] length;
  } head_sum_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hrhc_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrhc_parser
// Byte-at-a-time scanner of an HTTP/1.1 request head. Holds the line and
// header state, and gives the head summary for the byte that ends the head.
// ----------------------------------------------------------------------------
module hrhc_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire hrhc_pkg::in_item_t item,
  output hrhc_pkg::head_sum_t    sum
);
  import hrhc_pkg::*;

  localparam int CL_LEN = 14;
  localparam int TE_LEN = 17;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Largest accumulator value that can still take another digit
  localparam logic [63:0] ACC_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF / 64'd10;
  localparam logic [3:0]  ACC_LAST  = 4'(64'hFFFF_FFFF_FFFF_FFFF % 64'd10);

  localparam logic [7:0] CL_NAME [CL_LEN] = '{
    "c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h"
  };
  localparam logic [7:0] TE_NAME [TE_LEN] = '{
    "t", "r", "a", "n", "s", "f", "e", "r", "-",
    "e", "n", "c", "o", "d", "i", "n", "g"
  };

  typedef enum logic [1:0] {
    PH_START, PH_NAME_LEAD, PH_NAME, PH_VALUE
  } phase_t;

  typedef enum logic [1:0] {
    VP_LEAD, VP_DIGITS, VP_TRAIL, VP_BAD
  } vphase_t;

  typedef struct packed {
    logic        on_first;
    phase_t      phase;
    logic [1:0]  spaces;
    logic        pend_cr;
    logic [3:0]  cl_pos;
    logic        cl_alive;
    logic [4:0]  te_pos;
    logic        te_alive;
    logic        trail;
    vphase_t     vphase;
    logic [63:0] accum;
    logic        seen;
    logic [63:0] kept;
    err_code_t   err;
  } pst_t;

  localparam pst_t PST_RESET = '{
    on_first: 1'b1, phase: PH_START, spaces: 2'd0, pend_cr: 1'b0,
    cl_pos: 4'd0, cl_alive: 1'b1, te_pos: 5'd0, te_alive: 1'b1,
    trail: 1'b0, vphase: VP_LEAD, accum: 64'd0, seen: 1'b0,
    kept: 64'd0, err: ERR_NONE
  };

  function automatic logic is_ws(logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF ||
           c == CH_FF || c == CH_VT;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // Effect of one ordinary byte of a line
  function automatic pst_t char_step(pst_t s, logic [7:0] c);
    pst_t       n;
    logic [7:0] lc;
    logic [3:0] d;
    logic       cl_ok;
    logic       te_ok;
    n     = s;
    lc    = to_lower(c);
    d     = 4'(c - CH_ZERO);
    cl_ok = 1'b0;
    te_ok = 1'b0;
    if (s.err == ERR_NONE) begin
      if (s.on_first) begin
        if (c == CH_SP && s.spaces != 2'd2) n.spaces = s.spaces + 2'd1;
      end else if (s.phase == PH_START && (c == CH_SP || c == CH_TAB)) begin
        n.err = ERR_FOLDED;
      end else if (s.phase != PH_VALUE) begin
        // name part
        if (c == CH_COLON) begin
          n.phase = PH_VALUE;
        end else if (is_ws(c)) begin
          if (s.phase == PH_START) n.phase = PH_NAME_LEAD;
          else if (s.phase == PH_NAME) n.trail = 1'b1;
        end else begin
          n.phase = PH_NAME;
          if (s.cl_alive && !s.trail && s.cl_pos < 4'(CL_LEN)) begin
            cl_ok = (CL_NAME[s.cl_pos] == lc);
          end
          if (s.te_alive && !s.trail && s.te_pos < 5'(TE_LEN)) begin
            te_ok = (TE_NAME[s.te_pos] == lc);
          end
          if (cl_ok) n.cl_pos = s.cl_pos + 4'd1;
          else       n.cl_alive = 1'b0;
          if (te_ok) n.te_pos = s.te_pos + 5'd1;
          else       n.te_alive = 1'b0;
        end
      end else if (s.cl_alive && s.cl_pos == 4'(CL_LEN) && s.vphase != VP_BAD) begin
        // Content-Length value
        if (c >= CH_ZERO && c <= CH_NINE) begin
          if (s.vphase == VP_TRAIL) begin
            n.vphase = VP_BAD;
          end else if (s.accum > ACC_LIMIT || (s.accum == ACC_LIMIT && d > ACC_LAST)) begin
            n.vphase = VP_BAD;
          end else begin
            n.accum  = (s.accum << 3) + (s.accum << 1) + 64'(d);
            n.vphase = VP_DIGITS;
          end
        end else if (is_ws(c)) begin
          if (s.vphase == VP_DIGITS) n.vphase = VP_TRAIL;
        end else begin
          n.vphase = VP_BAD;
        end
      end
    end
    return n;
  endfunction

  // Checks at the end of a line, then line state back to start
  function automatic pst_t line_end(pst_t s);
    pst_t n;
    n = s;
    if (s.err == ERR_NONE) begin
      if (s.on_first) begin
        if (s.spaces != 2'd2) n.err = ERR_REQ_LINE;
      end else if (s.phase == PH_NAME_LEAD || s.phase == PH_NAME) begin
        n.err = ERR_NO_COLON;
      end else if (s.phase == PH_VALUE) begin
        if (s.cl_alive && s.cl_pos == 4'(CL_LEN)) begin
          if (s.vphase == VP_LEAD || s.vphase == VP_BAD) begin
            n.err = ERR_BAD_LEN;
          end else if (s.seen && s.accum != s.kept) begin
            n.err = ERR_CONFLICT;
          end else begin
            n.kept = s.accum;
            n.seen = 1'b1;
          end
        end
        if (n.err == ERR_NONE && s.te_alive && s.te_pos == 5'(TE_LEN)) n.err = ERR_CHUNKED;
      end
    end
    n.on_first = 1'b0;
    n.phase    = PH_START;
    n.spaces   = 2'd0;
    n.cl_pos   = 4'd0;
    n.cl_alive = 1'b1;
    n.te_pos   = 5'd0;
    n.te_alive = 1'b1;
    n.trail    = 1'b0;
    n.vphase   = VP_LEAD;
    n.accum    = 64'd0;
    return n;
  endfunction

  pst_t st_r;
  pst_t st_nxt;
  pst_t st_byte;
  pst_t st_end;

  // Byte handling: CR is held back one byte so a CR before LF is dropped
  always_comb begin
    st_byte = st_r;
    if (item.head_byte == CH_LF) begin
      st_byte.pend_cr = 1'b0;
    end else if (item.head_byte == CH_CR) begin
      if (st_r.pend_cr) st_byte = char_step(st_r, CH_CR);
      st_byte.pend_cr = 1'b1;
    end else begin
      if (st_r.pend_cr) st_byte = char_step(st_r, CH_CR);
      st_byte = char_step(st_byte, item.head_byte);
      st_byte.pend_cr = 1'b0;
    end
    st_end = (item.head_byte == CH_LF || item.last) ? line_end(st_byte) : st_byte;
    st_end.pend_cr = st_end.pend_cr && !item.last;
  end

  // Summary for the final byte
  always_comb begin
    sum.err    = st_end.err;
    sum.length = st_end.seen ? st_end.kept : 64'd0;
  end

  // Next state: back to reset after the verdict
  always_comb begin
    st_nxt = st_r;
    if (step) st_nxt = item.last ? PST_RESET : st_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= PST_RESET;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/http_request_head_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// http_request_head_checker
// Checks the head of an HTTP/1.1 request and reports one verdict per head.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one head byte per item; last marks the final byte (the closing
//            blank line is not sent). Items of one head follow in order.
//   out_*  : one verdict item per head: accepted, error_code, body_length.
//   cfg_*  : writes max_body_bytes; always ready, write it only while idle.
// Throughput is one byte per cycle, set by the parse state update, while a held verdict does not stall the input.
// From the edge that accepts the last byte, the byte is parsed out of the input
// register into the summary register, then the size-limit compare loads the
// output register, which raises out_valid.
// Reset (rst_n low, synchronous) empties all stages, returns the parser to the
// start of a head and loads max_body_bytes with 1048576.
// When out_ready is low the verdict holds; bytes keep flowing until a second
// verdict waits in the summary register and the last byte of a third head
// reaches the input register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module http_request_head_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hrhc_pkg::in_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output hrhc_pkg::out_item_t     out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [63:0]        cfg_max_body_bytes
);
  import hrhc_pkg::*;

  localparam logic [63:0] MAX_BODY_RESET = 64'd1048576;

  logic        in_valid_r;
  in_item_t    in_item_r;
  logic        sum_valid_r;
  head_sum_t   sum_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic [63:0] max_body_r;

  head_sum_t   sum;
  err_code_t   code;
  logic        s1_go;
  logic        s2_go;
  logic        s2_free;

  // Flow control: stage 1 holds a byte, stage 2 a head summary
  assign s2_go     = sum_valid_r && (!out_valid_r || out_ready);
  assign s2_free   = !sum_valid_r || s2_go;
  assign s1_go     = in_valid_r && (!in_item_r.last || s2_free);
  assign in_ready  = !in_valid_r || s1_go;
  assign cfg_ready = 1'b1;

  hrhc_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_go),
    .item  (in_item_r),
    .sum   (sum)
  );

  // Size limit applies only to an otherwise clean head
  always_comb begin
    code = sum_r.err;
    if (sum_r.err == ERR_NONE && sum_r.length > max_body_r) code = ERR_TOO_LARGE;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
    if (in_valid && in_ready) in_item_r <= in_item;
  end

  // Summary register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= 1'b0;
    end else if (s2_free) begin
      sum_valid_r <= s1_go && in_item_r.last;
    end
    if (s2_free && s1_go && in_item_r.last) sum_r <= sum;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= sum_valid_r;
    end
    if (s2_go) begin
      out_item_r.accepted    <= (code == ERR_NONE);
      out_item_r.error_code  <= code;
      out_item_r.body_length <= (code == ERR_NONE) ? sum_r.length : 64'd0;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r <= MAX_BODY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_body_r <= cfg_max_body_bytes;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks
  `ASSERT_CLK(a_sum_hold, sum_valid_r && !s2_go |=> sum_valid_r && $stable(sum_r), "summary lost")
  `ASSERT_CLK(a_in_stall, !in_ready |-> in_valid_r && !s1_go, "input stalled without cause")
  `ASSERT_CLK(a_verdict, out_valid && !out_item.accepted |-> out_item.body_length == 64'd0 && out_item.error_code != ERR_NONE, "bad verdict")
  `ASSERT_ALWAYS(a_reset, !rst_n |=> !out_valid && !sum_valid_r && !in_valid_r, "not empty after reset")

endmodule
`default_nettype wire

// ===== tb/sv/head_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// head_verdict_checker
// Watches the byte, verdict and limit channels of the request-head checker.
// It parses every accepted byte on its own, queues the verdict expected at
// each head end and compares every accepted verdict with the oldest one due.
// ----------------------------------------------------------------------------
module head_verdict_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  hrhc_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  hrhc_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [63:0]         cfg_max_body_bytes,
  output int                  verdicts_pending,
  output int                  mismatches
);
  import hrhc_pkg::*;

  localparam logic [8*14-1:0] LEN_NAME       = "content-length";
  localparam logic [8*17-1:0] ENC_NAME       = "transfer-encoding";
  localparam int              LEN_NAME_CHARS = 14;
  localparam int              ENC_NAME_CHARS = 17;
  localparam logic [63:0]     LIMIT_AT_RESET = 64'd1048576;
  localparam logic [63:0]     TENTH_OF_MAX   = 64'd1844674407370955161;
  localparam logic [7:0]      CH_TAB   = 8'h09;
  localparam logic [7:0]      CH_LF    = 8'h0A;
  localparam logic [7:0]      CH_VT    = 8'h0B;
  localparam logic [7:0]      CH_FF    = 8'h0C;
  localparam logic [7:0]      CH_CR    = 8'h0D;
  localparam logic [7:0]      CH_SPACE = 8'h20;
  localparam logic [7:0]      CH_COLON = 8'h3A;
  localparam logic [7:0]      CH_ZERO  = 8'h30;
  localparam logic [7:0]      CH_NINE  = 8'h39;
  localparam logic [7:0]      CH_UP_A  = 8'h41;
  localparam logic [7:0]      CH_UP_Z  = 8'h5A;

  // Where the parser stands within a header line and within its value
  typedef enum logic [1:0] {AT_LINE_START, IN_NAME_LEAD, IN_NAME, IN_VALUE} line_pos_e;
  typedef enum logic [1:0] {VAL_LEAD, VAL_DIGITS, VAL_TRAIL, VAL_BAD} val_pos_e;

  // Predicted parser state
  logic [63:0] body_limit;
  bit          first_line;
  line_pos_e   line_pos;
  logic [1:0]  spaces;
  bit          cr_held;
  logic [4:0]  len_pos;
  logic [4:0]  enc_pos;
  bit          len_live;
  bit          enc_live;
  bit          name_gap;
  val_pos_e    val_pos;
  logic [63:0] digits_val;
  bit          have_len;
  logic [63:0] kept_len;
  err_code_t   head_err;

  out_item_t   verdicts_due[$];
  int          fail_count = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t ns: verdict %s: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic bit is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF ||
           c == CH_FF || c == CH_VT;
  endfunction

  function automatic bit length_named();
    return len_live && len_pos == LEN_NAME_CHARS;
  endfunction

  function automatic void new_line();
    line_pos   = AT_LINE_START;
    spaces     = '0;
    len_pos    = '0;
    len_live   = 1'b1;
    enc_pos    = '0;
    enc_live   = 1'b1;
    name_gap   = 1'b0;
    val_pos    = VAL_LEAD;
    digits_val = '0;
  endfunction

  function automatic void new_head();
    new_line();
    first_line = 1'b1;
    cr_held    = 1'b0;
    have_len   = 1'b0;
    kept_len   = '0;
    head_err   = ERR_NONE;
  endfunction

  // One character of a line (line breaks already taken out)
  function automatic void parse_char(input logic [7:0] c);
    logic [7:0]  lc;
    logic [63:0] d;
    if (head_err != ERR_NONE) return;
    if (first_line) begin
      if (c == CH_SPACE && spaces < 2'd2) spaces = spaces + 2'd1;
      return;
    end
    if (line_pos == AT_LINE_START) begin
      if (c == CH_SPACE || c == CH_TAB) begin
        head_err = ERR_FOLDED;
        return;
      end
      line_pos = IN_NAME_LEAD;
    end
    // header name: track both names while they still match
    if (line_pos != IN_VALUE) begin
      if (c == CH_COLON) begin
        line_pos = IN_VALUE;
      end else if (is_space(c)) begin
        if (line_pos == IN_NAME) name_gap = 1'b1;
      end else begin
        lc = (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
        line_pos = IN_NAME;
        if (name_gap) begin
          len_live = 1'b0;
          enc_live = 1'b0;
        end
        if (len_live && len_pos < LEN_NAME_CHARS &&
            LEN_NAME[8*(LEN_NAME_CHARS - 1 - int'(len_pos)) +: 8] == lc)
          len_pos = len_pos + 5'd1;
        else
          len_live = 1'b0;
        if (enc_live && enc_pos < ENC_NAME_CHARS &&
            ENC_NAME[8*(ENC_NAME_CHARS - 1 - int'(enc_pos)) +: 8] == lc)
          enc_pos = enc_pos + 5'd1;
        else
          enc_live = 1'b0;
      end
      return;
    end
    // value: only a length value is looked at
    if (!length_named() || val_pos == VAL_BAD) return;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 64'(c - CH_ZERO);
      if (val_pos == VAL_TRAIL) begin
        val_pos = VAL_BAD;
      end else if (digits_val > TENTH_OF_MAX || (digits_val == TENTH_OF_MAX && d > 64'd5)) begin
        val_pos = VAL_BAD;
      end else begin
        digits_val = digits_val * 64'd10 + d;
        val_pos    = VAL_DIGITS;
      end
    end else if (is_space(c)) begin
      if (val_pos == VAL_DIGITS) val_pos = VAL_TRAIL;
    end else begin
      val_pos = VAL_BAD;
    end
  endfunction

  function automatic void close_line();
    if (head_err == ERR_NONE) begin
      if (first_line) begin
        if (spaces < 2'd2) head_err = ERR_REQ_LINE;
      end else if (line_pos == IN_NAME_LEAD || line_pos == IN_NAME) begin
        head_err = ERR_NO_COLON;
      end else if (line_pos == IN_VALUE) begin
        if (length_named()) begin
          if (val_pos == VAL_LEAD || val_pos == VAL_BAD)
            head_err = ERR_BAD_LEN;
          else if (have_len && digits_val != kept_len)
            head_err = ERR_CONFLICT;
          else begin
            kept_len = digits_val;
            have_len = 1'b1;
          end
        end
        if (head_err == ERR_NONE && enc_live && enc_pos == ENC_NAME_CHARS)
          head_err = ERR_CHUNKED;
      end
    end
    first_line = 1'b0;
    new_line();
  endfunction

  // One accepted byte; returns 1 with the verdict when the byte ends a head
  function automatic bit parse_byte(input logic [7:0] b, input logic fin,
                                    output out_item_t verdict);
    err_code_t   code;
    logic [63:0] len;
    verdict = '0;
    if (b == CH_LF) begin
      cr_held = 1'b0;
      close_line();
    end else if (b == CH_CR) begin
      if (cr_held) parse_char(CH_CR);
      cr_held = 1'b1;
    end else begin
      if (cr_held) begin
        parse_char(CH_CR);
        cr_held = 1'b0;
      end
      parse_char(b);
    end
    if (!fin) return 1'b0;
    cr_held = 1'b0;
    close_line();
    code = head_err;
    len  = have_len ? kept_len : '0;
    if (code == ERR_NONE && len > body_limit) code = ERR_TOO_LARGE;
    verdict.accepted    = (code == ERR_NONE);
    verdict.error_code  = code;
    verdict.body_length = (code == ERR_NONE) ? len : '0;
    new_head();
    return 1'b1;
  endfunction

  // Sample all three channels at the edge; verdicts go out before new bytes
  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t made;
    if (!rst_n) begin
      body_limit = LIMIT_AT_RESET;
      new_head();
      verdicts_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          report("with none due, accepted", 64'(out_item.accepted), 64'd0);
        end else begin
          want = verdicts_due.pop_front();
          if (out_item.accepted !== want.accepted)
            report("accepted", 64'(out_item.accepted), 64'(want.accepted));
          if (out_item.error_code !== want.error_code)
            report("error_code", 64'(out_item.error_code), 64'(want.error_code));
          if (out_item.body_length !== want.body_length)
            report("body_length", out_item.body_length, want.body_length);
        end
      end
      if (in_valid && in_ready) begin
        if (parse_byte(in_item.head_byte, in_item.last, made)) verdicts_due.push_back(made);
      end
      if (cfg_valid && cfg_ready) body_limit = cfg_max_body_bytes;
    end
    verdicts_pending <= verdicts_due.size();
    mismatches       <= fail_count;
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Feeds request heads byte by byte into the request-head checker: a short
// list of hand-made heads for every error code and corner, then random heads
// that are mostly well formed, under several body-size limits. The sender
// works in bursts, the receiver stalls on its own pattern, and the verdicts
// are checked by head_verdict_checker.
// ----------------------------------------------------------------------------
module tb;
  import hrhc_pkg::*;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_max_body_bytes = '0;
  int          verdicts_pending;
  int          mismatches;

  logic [7:0]  head_q[$];
  logic [63:0] cur_limit = 64'd1048576;
  logic [63:0] last_len = '0;
  bit          byte_up = 1'b0;
  int          burst_left = 0;
  int          bytes_sent = 0;
  int          ready_mode = 0;
  int          ready_span = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  http_request_head_checker u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_item           (in_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_item          (out_item),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_max_body_bytes(cfg_max_body_bytes)
  );

  head_verdict_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_item           (in_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_item          (out_item),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_max_body_bytes(cfg_max_body_bytes),
    .verdicts_pending  (verdicts_pending),
    .mismatches        (mismatches)
  );

  // Receiver: spans of always-ready, coin-flip, mostly-stalled and periodic
  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_span = $urandom_range(20, 200);
    end
    ready_span--;
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 1) == 1);
      2:       out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= (ready_span % 16) < 12;
    endcase
  end

  // Drop valid, but only if it is up, so it never gets two updates in a step
  task automatic hold_input();
    if (byte_up) in_valid <= 1'b0;
    byte_up    = 1'b0;
    burst_left = 0;
  endtask

  task automatic drive_byte(input logic [7:0] b, input logic fin);
    if (burst_left == 0) begin
      hold_input();
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= '{head_byte: b, last: fin};
    byte_up  = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_head();
    for (int i = 0; i < head_q.size(); i++) drive_byte(head_q[i], i == head_q.size() - 1);
    bytes_sent += head_q.size();
    head_q.delete();
  endtask

  // Sender pause until every verdict has been taken
  task automatic drain_wait();
    hold_input();
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [63:0] v);
    drain_wait();
    // let the last head clear the pipeline
    repeat (4) @(posedge clk);
    cfg_valid          <= 1'b1;
    cfg_max_body_bytes <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_limit = v;
  endtask

  task automatic put(input string s);
    for (int i = 0; i < s.len(); i++) head_q.push_back(s[i]);
  endtask

  task automatic head(input string s);
    put(s);
    send_head();
  endtask

  // Printable name characters, never a colon
  task automatic put_token(input int n);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom_range(8'h21, 8'h7E));
      head_q.push_back(c == ":" ? 8'h5F : c);
    end
  endtask

  // Any byte but LF, so the line stays whole
  task automatic put_text(input int n);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom_range(0, 255));
      head_q.push_back(c == CH_LF ? 8'h78 : c);
    end
  endtask

  task automatic put_noise(input int n);
    repeat (n) head_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_eol();
    int r;
    r = $urandom_range(0, 19);
    if (r >= 19) head_q.push_back(CH_CR);
    if (r < 14 || r >= 19) head_q.push_back(CH_CR);
    head_q.push_back(CH_LF);
  endtask

  task automatic put_length_value();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = 64'($urandom_range(0, 999));
      4, 5:       v = cur_limit + 64'($urandom_range(0, 2)) - 64'd1;
      6:          v = {$urandom, $urandom};
      7:          v = last_len;
      8: begin
        // right at the 64-bit edge: last digit 4 or 5 fits, 6 or 7 overflows
        put("1844674407370955161");
        head_q.push_back(8'h30 + 8'($urandom_range(4, 7)));
        return;
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       put("");
          1:       put("1x2");
          2:       put("1 2");
          default: put("-3");
        endcase
        return;
      end
    endcase
    last_len = v;
    put($sformatf("%0d", v));
  endtask

  task automatic build_random_head();
    int lines;
    if ($urandom_range(0, 19) == 0) begin
      put_noise($urandom_range(1, 10));
      return;
    end
    // request line, now and then with one space only
    put_token($urandom_range(1, 3));
    if ($urandom_range(0, 9) != 0) put(" ");
    put_token($urandom_range(1, 3));
    put(" HTTP/1.1");
    lines = $urandom_range(0, 3);
    repeat (lines) begin
      put_eol();
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: begin
          put_token($urandom_range(1, 6));
          put(":");
          if ($urandom_range(0, 1)) put(" ");
          put_text($urandom_range(0, 6));
        end
        7, 8, 9, 10, 11: begin
          case ($urandom_range(0, 3))
            0:       put("Content-Length");
            1:       put("content-length");
            2:       put("CONTENT-LENGTH");
            default: put("Content-Length\t");
          endcase
          put(":");
          repeat ($urandom_range(0, 2)) put(" ");
          put_length_value();
          if ($urandom_range(0, 3) == 0) put(" ");
        end
        12: begin
          if ($urandom_range(0, 1)) put("Transfer-Encoding: chunked");
          else put("transfer-ENCODING:x");
        end
        13, 14: ;  // empty line
        15: begin
          if ($urandom_range(0, 1)) put(" ");
          else put("\t");
          put_token($urandom_range(1, 4));
        end
        16: put_token($urandom_range(1, 6));
        17: begin
          case ($urandom_range(0, 3))
            0:       put("Content-Lengt: 5");
            1:       put("Content-Lengthx: 5");
            2:       put("Content Length: 5");
            default: put("Transfer-Encodin: x");
          endcase
        end
        default: put_noise($urandom_range(1, 8));
      endcase
    end
    case ($urandom_range(0, 9))
      0:       put_eol();
      1:       head_q.push_back(CH_CR);
      default: ;
    endcase
  endtask

  initial begin : stimulus
    logic [63:0] v;
    int heads;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // hand-made heads at the limit set by reset
    head("GET / HTTP/1.1");
    head("GET /");
    head("A B C\015\nContent-Length: 5");
    head("A B C\n X: 1");
    head("A B C\n\tX: 1");
    head("A B C\nHost");
    head("A B C\nContent-Length: 1a");
    head("A B C\nContent-Length:");
    head("A B C\ncontent-length: 18446744073709551616");
    head("A B C\nContent-Length: 18446744073709551615");
    head("A B C\nContent-Length: 7\nContent-Length: 8");
    head("A B C\nContent-Length: 7\nCONTENT-LENGTH : 7");
    head("A B C\nTransfer-Encoding: chunked");
    head("A B C\nContent-Length: 1048577");
    head("A B C\nContent-Length: 1048576");
    head("A B C\015\n\015\n\nHost: x");
    head("A B C\015\015\nX: a\015b\015");
    head("A\nContent-Length: zz");
    head("A B C\nContent Length: 5");
    head("A B C\nContent-Length:\t 12 \013\014");
    head("A B C\nContent-Length: 1 2");
    head("A B C\015\n");
    // zero and all-ones bytes in a header
    put("A B C\nX");
    head_q.push_back(8'h00);
    put(":");
    head_q.push_back(8'hFF);
    head_q.push_back(8'h00);
    send_head();

    // limit at both ends
    write_limit('1);
    head("A B C\nContent-Length: 18446744073709551615");
    write_limit('0);
    head("A B C\nContent-Length: 0");
    head("A B C\nContent-Length: 1");

    // random heads, limit changed every eighth head
    heads = 0;
    while (bytes_sent < 950 || heads < 8) begin
      if (heads % 8 == 7) begin
        case ($urandom_range(0, 4))
          0:       v = '0;
          1:       v = '1;
          2:       v = 64'd1048576;
          3:       v = 64'($urandom_range(0, 2000));
          default: v = {$urandom, $urandom};
        endcase
        write_limit(v);
      end else if (heads == 4 || $urandom_range(0, 14) == 0) begin
        drain_wait();
      end
      build_random_head();
      send_head();
      heads++;
    end

    drain_wait();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/hrhc_pkg.sv
hw/rtl/hrhc_parser.sv
hw/rtl/http_request_head_checker.sv
tb/sv/head_verdict_checker.sv
tb/sv/tb.sv
